FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/asa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activity statistics accumulator package
// Sample kind codes, queue entry format and divider handshake types.
// ----------------------------------------------------------------------------
package asa_pkg;

	localparam logic [2:0] OP_ALTITUDE = 3'd0;
	localparam logic [2:0] OP_DISTANCE = 3'd1;
	localparam logic [2:0] OP_SPEED    = 3'd2;
	localparam logic [2:0] OP_HEART    = 3'd3;
	localparam logic [2:0] OP_CADENCE  = 3'd4;

	localparam int SUM_W       = 48;
	localparam int VAL_W       = 32;
	localparam int QUEUE_DEPTH = 4;

	typedef logic signed [SUM_W-1:0] sum_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [VAL_W-2:0] CLIMB_MAX = '1;

	// One-hot sample kind; all zero for an unknown code.
	typedef struct packed {
		logic altitude;
		logic distance;
		logic speed;
		logic heart;
		logic cadence;
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic                    positive;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} entry_t;

	typedef struct packed {
		logic start;
		sum_t dividend;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [VAL_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: rtl/asa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one tagged activity sample per transfer.
// ----------------------------------------------------------------------------
interface asa_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic signed [31:0] sample_value;
	logic               last_sample;

	modport source (output valid, output operation, output sample_value,
		output last_sample, input ready);
	modport sink (input valid, input operation, input sample_value,
		input last_sample, output ready);
endinterface

FILE: rtl/asa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Summary channel
// Valid/ready channel carrying one activity summary per transfer.
// ----------------------------------------------------------------------------
interface asa_out_if;
	logic               valid;
	logic               ready;
	logic [30:0]        total_climb;
	logic signed [31:0] final_distance;
	logic [30:0]        peak_speed;
	logic signed [31:0] mean_speed;
	logic [30:0]        peak_heart_rate;
	logic [30:0]        mean_heart_rate;
	logic [30:0]        mean_cadence;

	modport source (output valid, output total_climb, output final_distance,
		output peak_speed, output mean_speed, output peak_heart_rate,
		output mean_heart_rate, output mean_cadence, input ready);
	modport sink (input valid, input total_climb, input final_distance,
		input peak_speed, input mean_speed, input peak_heart_rate,
		input mean_heart_rate, input mean_cadence, output ready);
endinterface

FILE: rtl/activity_statistics_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activity statistics accumulator
// Accumulates tagged activity samples and emits a summary with means on the
// sample marked last.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the back end accumulates; a four-entry
// queue sits between the classifier and the back end, and a sample is applied
// when the back end pops it. A last sample holds the back end while the shared
// one-bit-per-cycle divider forms three means (48 steps per mean); the summary
// follows. Reset clears every statistic at once; there is no clearing pass.
module activity_statistics_accumulator import asa_pkg::*; #(
	parameter int MAX_SAMPLES = 65536
) (
	input  logic      clk,
	input  logic      arst_n,
	asa_in_if.sink    samples,
	asa_out_if.source summary
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	logic             q_full;
	logic             push;
	entry_t           wr_entry;
	logic             pop;
	logic             q_valid;
	entry_t           rd_entry;
	div_req_t         div_req;
	logic [CNT_W-1:0] div_divisor;
	div_rsp_t         div_rsp;

	asa_front u_front (
		.samples (samples),
		.q_full  (q_full),
		.push    (push),
		.entry   (wr_entry)
	);

	asa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.rd_entry (rd_entry)
	);

	asa_divider #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.divisor (div_divisor),
		.rsp     (div_rsp)
	);

	asa_back #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (rd_entry),
		.pop         (pop),
		.div_req     (div_req),
		.div_divisor (div_divisor),
		.div_rsp     (div_rsp),
		.summary     (summary)
	);

endmodule

FILE: rtl/asa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample classifier
// Decodes the sample kind and sign and writes the entry into the queue.
// ----------------------------------------------------------------------------
module asa_front import asa_pkg::*; (
	asa_in_if.sink samples,
	input  logic   q_full,
	output logic   push,
	output entry_t entry
);

	assign samples.ready = !q_full;
	assign push          = samples.valid && !q_full;

	always_comb begin
		entry.kind = '0;
		case (samples.operation)
			OP_ALTITUDE: entry.kind.altitude = 1'b1;
			OP_DISTANCE: entry.kind.distance = 1'b1;
			OP_SPEED:    entry.kind.speed    = 1'b1;
			OP_HEART:    entry.kind.heart    = 1'b1;
			OP_CADENCE:  entry.kind.cadence  = 1'b1;
			default:     entry.kind          = '0;
		endcase
		entry.positive = !samples.sample_value[VAL_W-1] && (samples.sample_value != '0);
		entry.value    = samples.sample_value;
		entry.last     = samples.last_sample;
	end

endmodule

FILE: rtl/asa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entry queue
// Small FIFO between the classifier and the accumulator back end.
// ----------------------------------------------------------------------------
module asa_queue import asa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   pop,
	output logic   valid,
	output entry_t rd_entry
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W:0] DEPTH_V = (PTR_W+1)'(QUEUE_DEPTH);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full     = (cnt_q == DEPTH_V);
	assign valid    = (cnt_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_entry;
	end

endmodule

FILE: rtl/asa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mean divider
// Restoring divider, one quotient bit per cycle, signed sum by sample count,
// truncated toward zero and clamped to 32-bit signed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module asa_divider import asa_pkg::*; #(
	parameter int MAX_SAMPLES = 65536,
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [CNT_W-1:0] divisor,
	output div_rsp_t         rsp
);

	localparam int STEP_W = $clog2(SUM_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);
	localparam logic [SUM_W-1:0]  POS_LIM   = SUM_W'(32'h7FFF_FFFF);
	localparam logic [SUM_W-1:0]  NEG_LIM   = SUM_W'(32'h8000_0000);

	logic                    busy_q;
	logic                    fin_q;
	logic                    neg_q;
	logic [STEP_W-1:0]       step_q;
	logic [CNT_W-1:0]        rem_q;
	logic [SUM_W-1:0]        quo_q;
	logic [CNT_W-1:0]        dsr_q;
	logic signed [VAL_W-1:0] res_q;
	logic                    done_q;

	logic [CNT_W:0]          rem_shift;
	logic                    fits;
	logic [CNT_W:0]          rem_next;
	logic [SUM_W-1:0]        mag;
	logic signed [VAL_W-1:0] clamped;

	always_comb begin
		rem_shift = {rem_q, quo_q[SUM_W-1]};
		fits      = (rem_shift >= {1'b0, dsr_q});
		rem_next  = fits ? (rem_shift - {1'b0, dsr_q}) : rem_shift;
		mag       = req.dividend[SUM_W-1] ? (-req.dividend) : req.dividend;
		if (!neg_q)
			clamped = (quo_q > POS_LIM) ? 32'sh7FFF_FFFF : quo_q[VAL_W-1:0];
		else
			clamped = (quo_q > NEG_LIM) ? 32'sh8000_0000 : (-quo_q[VAL_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			neg_q  <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
			res_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (divisor == '0) begin
					res_q  <= '0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					step_q <= '0;
					rem_q  <= '0;
					quo_q  <= mag;
					dsr_q  <= divisor;
					neg_q  <= req.dividend[SUM_W-1];
				end
			end else if (busy_q) begin
				rem_q  <= rem_next[CNT_W-1:0];
				quo_q  <= {quo_q[SUM_W-2:0], fits};
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				res_q  <= clamped;
				done_q <= 1'b1;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = res_q;

	`ASSERT_CLK(a_start_idle, clk, arst_n, req.start |-> (!busy_q && !fin_q), "divider started while busy")
	`ASSERT_CLK(a_done_pulse, clk, arst_n, done_q |=> !done_q, "divider done held for two cycles")

endmodule

FILE: rtl/asa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Statistics back end
// Applies queued samples to the running statistics, runs the three means
// through the shared divider on a last sample and registers the summary.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module asa_back import asa_pkg::*; #(
	parameter int MAX_SAMPLES = 65536,
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  entry_t           q_entry,
	output logic             pop,
	output div_req_t         div_req,
	output logic [CNT_W-1:0] div_divisor,
	input  div_rsp_t         div_rsp,
	asa_out_if.source        summary
);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;

	localparam logic [1:0] SEL_SPEED   = 2'd0;
	localparam logic [1:0] SEL_HEART   = 2'd1;
	localparam logic [1:0] SEL_CADENCE = 2'd2;

	function automatic sum_t sat_add(sum_t s, logic signed [VAL_W-1:0] v);
		logic [SUM_W:0] t;
		begin
			t = {s[SUM_W-1], s} + {{(SUM_W-VAL_W+1){v[VAL_W-1]}}, v};
			if (t[SUM_W] != t[SUM_W-1])
				sat_add = t[SUM_W] ? SUM_MIN : SUM_MAX;
			else
				sat_add = t[SUM_W-1:0];
		end
	endfunction

	logic [1:0]              state_q;
	logic [1:0]              div_sel_q;
	logic                    div_pend_q;

	logic signed [VAL_W-1:0] prev_alt_q;
	logic [VAL_W-2:0]        climb_q;
	logic signed [VAL_W-1:0] dist_q;
	logic [VAL_W-2:0]        speed_pk_q;
	sum_t                    speed_sum_q;
	logic [CNT_W-1:0]        speed_cnt_q;
	logic [VAL_W-2:0]        heart_pk_q;
	sum_t                    heart_sum_q;
	logic [CNT_W-1:0]        heart_cnt_q;
	sum_t                    cad_sum_q;
	logic [CNT_W-1:0]        cad_cnt_q;

	logic signed [VAL_W-1:0] mean_speed_q;
	logic [VAL_W-2:0]        mean_heart_q;
	logic [VAL_W-2:0]        mean_cad_q;

	logic                    out_valid_q;
	logic [VAL_W-2:0]        o_climb_q;
	logic signed [VAL_W-1:0] o_dist_q;
	logic [VAL_W-2:0]        o_speed_pk_q;
	logic signed [VAL_W-1:0] o_speed_mean_q;
	logic [VAL_W-2:0]        o_heart_pk_q;
	logic [VAL_W-2:0]        o_heart_mean_q;
	logic [VAL_W-2:0]        o_cad_mean_q;

	logic signed [VAL_W-1:0] v;
	logic [VAL_W-1:0]        rise;
	logic [VAL_W:0]          climb_ext;
	logic                    load;

	logic signed [VAL_W-1:0] prev_alt_d;
	logic [VAL_W-2:0]        climb_d;
	logic signed [VAL_W-1:0] dist_d;
	logic [VAL_W-2:0]        speed_pk_d;
	sum_t                    speed_sum_d;
	logic [CNT_W-1:0]        speed_cnt_d;
	logic [VAL_W-2:0]        heart_pk_d;
	sum_t                    heart_sum_d;
	logic [CNT_W-1:0]        heart_cnt_d;
	sum_t                    cad_sum_d;
	logic [CNT_W-1:0]        cad_cnt_d;

	assign pop  = (state_q == ST_RUN) && q_valid;
	assign load = (state_q == ST_OUT) && (!out_valid_q || summary.ready);

	always_comb begin
		v         = q_entry.value;
		rise      = v - prev_alt_q;
		climb_ext = {2'b00, climb_q} + {1'b0, rise};

		prev_alt_d  = prev_alt_q;
		climb_d     = climb_q;
		dist_d      = dist_q;
		speed_pk_d  = speed_pk_q;
		speed_sum_d = speed_sum_q;
		speed_cnt_d = speed_cnt_q;
		heart_pk_d  = heart_pk_q;
		heart_sum_d = heart_sum_q;
		heart_cnt_d = heart_cnt_q;
		cad_sum_d   = cad_sum_q;
		cad_cnt_d   = cad_cnt_q;

		if (q_entry.kind.altitude) begin
			// Climb only counts rises from an altitude that was above zero.
			if ((v > prev_alt_q) && (prev_alt_q > 0))
				climb_d = (climb_ext > {2'b00, CLIMB_MAX}) ? CLIMB_MAX : climb_ext[VAL_W-2:0];
			prev_alt_d = v;
		end
		if (q_entry.kind.distance)
			dist_d = v;
		if (q_entry.kind.speed) begin
			if (v >= $signed({1'b0, speed_pk_q}))
				speed_pk_d = v[VAL_W-2:0];
			if (speed_cnt_q < CNT_MAX) begin
				speed_sum_d = sat_add(speed_sum_q, v);
				speed_cnt_d = speed_cnt_q + 1'b1;
			end
		end
		if (q_entry.kind.heart && q_entry.positive) begin
			if (v > $signed({1'b0, heart_pk_q}))
				heart_pk_d = v[VAL_W-2:0];
			if (heart_cnt_q < CNT_MAX) begin
				heart_sum_d = sat_add(heart_sum_q, v);
				heart_cnt_d = heart_cnt_q + 1'b1;
			end
		end
		if (q_entry.kind.cadence && q_entry.positive) begin
			if (cad_cnt_q < CNT_MAX) begin
				cad_sum_d = sat_add(cad_sum_q, v);
				cad_cnt_d = cad_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		div_req.start = div_pend_q;
		case (div_sel_q)
			SEL_SPEED: begin
				div_req.dividend = speed_sum_q;
				div_divisor      = speed_cnt_q;
			end
			SEL_HEART: begin
				div_req.dividend = heart_sum_q;
				div_divisor      = heart_cnt_q;
			end
			SEL_CADENCE: begin
				div_req.dividend = cad_sum_q;
				div_divisor      = cad_cnt_q;
			end
			default: begin
				div_req.dividend = '0;
				div_divisor      = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			div_sel_q    <= SEL_SPEED;
			div_pend_q   <= 1'b0;
			prev_alt_q   <= '0;
			climb_q      <= '0;
			dist_q       <= '0;
			speed_pk_q   <= '0;
			speed_sum_q  <= '0;
			speed_cnt_q  <= '0;
			heart_pk_q   <= '0;
			heart_sum_q  <= '0;
			heart_cnt_q  <= '0;
			cad_sum_q    <= '0;
			cad_cnt_q    <= '0;
			mean_speed_q <= '0;
			mean_heart_q <= '0;
			mean_cad_q   <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (pop) begin
						prev_alt_q  <= prev_alt_d;
						climb_q     <= climb_d;
						dist_q      <= dist_d;
						speed_pk_q  <= speed_pk_d;
						speed_sum_q <= speed_sum_d;
						speed_cnt_q <= speed_cnt_d;
						heart_pk_q  <= heart_pk_d;
						heart_sum_q <= heart_sum_d;
						heart_cnt_q <= heart_cnt_d;
						cad_sum_q   <= cad_sum_d;
						cad_cnt_q   <= cad_cnt_d;
						if (q_entry.last) begin
							state_q    <= ST_DIV;
							div_sel_q  <= SEL_SPEED;
							div_pend_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					div_pend_q <= 1'b0;
					if (div_rsp.done) begin
						case (div_sel_q)
							SEL_SPEED:   mean_speed_q <= div_rsp.quotient;
							SEL_HEART:   mean_heart_q <= div_rsp.quotient[VAL_W-2:0];
							SEL_CADENCE: mean_cad_q   <= div_rsp.quotient[VAL_W-2:0];
							default:     mean_cad_q   <= mean_cad_q;
						endcase
						if (div_sel_q == SEL_CADENCE) begin
							state_q <= ST_OUT;
						end else begin
							div_sel_q  <= div_sel_q + 1'b1;
							div_pend_q <= 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (load) begin
						// The summary is captured; start the next activity from zero.
						state_q     <= ST_RUN;
						prev_alt_q  <= '0;
						climb_q     <= '0;
						dist_q      <= '0;
						speed_pk_q  <= '0;
						speed_sum_q <= '0;
						speed_cnt_q <= '0;
						heart_pk_q  <= '0;
						heart_sum_q <= '0;
						heart_cnt_q <= '0;
						cad_sum_q   <= '0;
						cad_cnt_q   <= '0;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (summary.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			o_climb_q      <= climb_q;
			o_dist_q       <= dist_q;
			o_speed_pk_q   <= speed_pk_q;
			o_speed_mean_q <= mean_speed_q;
			o_heart_pk_q   <= heart_pk_q;
			o_heart_mean_q <= mean_heart_q;
			o_cad_mean_q   <= mean_cad_q;
		end
	end

	assign summary.valid           = out_valid_q;
	assign summary.total_climb     = o_climb_q;
	assign summary.final_distance  = o_dist_q;
	assign summary.peak_speed      = o_speed_pk_q;
	assign summary.mean_speed      = o_speed_mean_q;
	assign summary.peak_heart_rate = o_heart_pk_q;
	assign summary.mean_heart_rate = o_heart_mean_q;
	assign summary.mean_cadence    = o_cad_mean_q;

	`ASSERT_ALWAYS(a_cnt_bound, clk, (speed_cnt_q <= CNT_MAX) && (heart_cnt_q <= CNT_MAX) && (cad_cnt_q <= CNT_MAX), "sample count beyond limit")
	`ASSERT_CLK(a_clear_after_load, clk, arst_n, load |=> ((speed_cnt_q == '0) && (heart_cnt_q == '0) && (cad_cnt_q == '0) && (climb_q == '0)), "statistics not cleared after summary")

endmodule
